// ===== rtl/lfsm_pkg.sv =====
// shared constants, types and helper functions of the line fixed string matcher
`timescale 1ns / 1ps

package lfsm_pkg;

    // pattern and window sizing
    localparam int MAX_PATTERN  = 32;
    localparam int WIN_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLEN_W       = 6;
    localparam int PATTERN_BITS = 256;

    // line length counter and reported length
    localparam int LENGTH_BITS = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int LEN_WIDE_W  = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;
    localparam logic [LENGTH_BITS-1:0] LEN_CAP     = {LENGTH_BITS{1'b1}};
    localparam logic [LEN_OUT_W-1:0]   LEN_OUT_MAX = {LEN_OUT_W{1'b1}};

    // occurrence counter
    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // special bytes
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_RETURN  = 8'h0D;
    localparam logic [7:0] FOLD_BIT     = 8'h20;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_IGNORE_CASE    = 3'd1,
        REG_PATTERN_WORD_0 = 3'd2,
        REG_PATTERN_WORD_1 = 3'd3,
        REG_PATTERN_WORD_2 = 3'd4,
        REG_PATTERN_WORD_3 = 3'd5
    } t_cfg_reg;

    // configuration seen by the window compare
    typedef struct packed {
        logic [PLEN_W-1:0]       len_eff;
        logic                    ignore_case;
        logic [PATTERN_BITS-1:0] pattern;
    } t_cfg;

    // fold letters to lower case when case is ignored
    function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
        logic letter;
        letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
        return (ic && letter) ? (b | FOLD_BIT) : b;
    endfunction

    // clamp the programmed pattern length to 1..MAX_PATTERN
    function automatic logic [PLEN_W-1:0] eff_length(input logic [PLEN_W-1:0] pl);
        logic [PLEN_W-1:0] n;
        n = pl;
        if (pl == '0) begin
            n = PLEN_W'(1);
        end else if (pl > PLEN_W'(MAX_PATTERN)) begin
            n = PLEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

    // saturating increment of the line length
    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] l);
        return (l < LEN_CAP) ? l + LENGTH_BITS'(1) : l;
    endfunction

    // reported length, saturated to the output width
    function automatic logic [LEN_OUT_W-1:0] len_out(input logic [LENGTH_BITS-1:0] l);
        logic [LEN_WIDE_W-1:0] wide;
        wide = LEN_WIDE_W'(l);
        return (wide > LEN_WIDE_W'(LEN_OUT_MAX)) ? LEN_OUT_MAX : wide[LEN_OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/lfsm_in_if.sv =====
// text byte channel
`timescale 1ns / 1ps

interface lfsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source(output valid, output text_byte, output end_of_text, input ready);
    modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/lfsm_out_if.sv =====
// line result channel
`timescale 1ns / 1ps

interface lfsm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         line_matched;
    logic [lfsm_pkg::COUNT_W-1:0]   occurrence_count;
    logic [lfsm_pkg::LEN_OUT_W-1:0] line_length;

    modport source(output valid, output line_matched, output occurrence_count,
                   output line_length, input ready);
    modport sink(input valid, input line_matched, input occurrence_count,
                 input line_length, output ready);
endinterface

// ===== rtl/lfsm_window.sv =====
// byte window shift register with parallel compare against the aligned pattern
`timescale 1ns / 1ps

module lfsm_window (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [7:0]          i_byte,
    input  lfsm_pkg::t_cfg      i_cfg,
    output logic                o_match
);
    import lfsm_pkg::*;

    logic [7:0] r_win     [MAX_PATTERN];
    logic [7:0] r_aligned [MAX_PATTERN];
    logic       r_mask    [MAX_PATTERN];
    logic [7:0] n_aligned [MAX_PATTERN];
    logic       n_mask    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq;

    // pattern byte n-1-j lines up with window slot j
    always_comb begin
        logic [PLEN_W-1:0]    pos;
        logic [WIN_IDX_W-1:0] idx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos          = i_cfg.len_eff - PLEN_W'(1) - PLEN_W'(j);
            idx          = pos[WIN_IDX_W-1:0];
            n_mask[j]    = (PLEN_W'(j) < i_cfg.len_eff);
            n_aligned[j] = fold(i_cfg.pattern[idx*8 +: 8], i_cfg.ignore_case);
        end
    end

    // aligned pattern follows the configuration in the next cycle
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            r_aligned[j] <= n_aligned[j];
            r_mask[j]    <= n_mask[j];
        end
    end

    // newest byte enters slot 0
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= i_byte;
            for (int j = 1; j < MAX_PATTERN; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    // compare the window as it stands after taking the new byte
    always_comb begin
        eq[0] = !r_mask[0] || (fold(i_byte, i_cfg.ignore_case) == r_aligned[0]);
        for (int j = 1; j < MAX_PATTERN; j++) begin
            eq[j] = !r_mask[j] || (fold(r_win[j-1], i_cfg.ignore_case) == r_aligned[j]);
        end
    end

    assign o_match = &eq;

endmodule

// ===== rtl/line_fixed_string_matcher_top.sv =====
// Line fixed string matcher: per-line count of non-overlapping pattern hits.
// A byte is registered in the input stage on transfer; a byte that closes a line has
// its result registered in the result stage. Throughput: one byte per cycle unless
// a closing byte waits on a stalled result; the window compare is one parallel stage.
// Reset (synchronous, active low) restores the register defaults and clears line state.
`timescale 1ns / 1ps

module line_fixed_string_matcher_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lfsm_in_if.sink                            i_in,
    lfsm_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [lfsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfsm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lfsm_pkg::*;

    localparam int BSR_W = PLEN_W;

    // configuration registers
    logic [PLEN_W-1:0]     r_plen;
    logic                  r_ic;
    logic [CFG_DATA_W-1:0] r_pword [4];
    t_cfg                  cfg;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // line state
    logic [BSR_W-1:0]       r_bsr;
    logic [COUNT_W-1:0]     r_occ;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_ret;

    // result stage
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_occ;
    logic [LEN_OUT_W-1:0] r_out_len;

    logic                   is_nl;
    logic                   is_cr;
    logic                   emit;
    logic                   out_free;
    logic                   advance;
    logic                   match;
    logic                   hit;
    logic [BSR_W-1:0]       bsr_inc;
    logic [COUNT_W-1:0]     occ_take;
    logic [LENGTH_BITS-1:0] len_mid;
    logic [LENGTH_BITS-1:0] len_take;
    logic [BSR_W-1:0]       n_bsr;
    logic [COUNT_W-1:0]     n_occ;
    logic [LENGTH_BITS-1:0] n_len;
    logic                   n_ret;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= PLEN_W'(1);
            r_ic   <= 1'b0;
            for (int w = 0; w < 4; w++) begin
                r_pword[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LENGTH: r_plen     <= i_cfg_data[PLEN_W-1:0];
                REG_IGNORE_CASE:    r_ic       <= i_cfg_data[0];
                REG_PATTERN_WORD_0: r_pword[0] <= i_cfg_data;
                REG_PATTERN_WORD_1: r_pword[1] <= i_cfg_data;
                REG_PATTERN_WORD_2: r_pword[2] <= i_cfg_data;
                REG_PATTERN_WORD_3: r_pword[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.len_eff     = eff_length(r_plen);
    assign cfg.ignore_case = r_ic;
    assign cfg.pattern     = {r_pword[3], r_pword[2], r_pword[1], r_pword[0]};

    // handshake between the stages
    assign is_nl    = (r_in_byte == BYTE_NEWLINE);
    assign is_cr    = (r_in_byte == BYTE_RETURN);
    assign emit     = is_nl || r_in_last;
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.text_byte;
            r_in_last <= i_in.end_of_text;
        end
    end

    lfsm_window u_window (
        .i_clk   (i_clk),
        .i_shift (advance && !is_nl),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_match (match)
    );

    // hit detection and counter updates for a line byte
    assign bsr_inc  = (r_bsr < BSR_W'(MAX_PATTERN)) ? r_bsr + BSR_W'(1) : r_bsr;
    assign hit      = (bsr_inc >= cfg.len_eff) && match;
    assign occ_take = (hit && (r_occ < COUNT_MAX)) ? r_occ + COUNT_W'(1) : r_occ;
    assign len_mid  = r_ret ? len_inc(r_len) : r_len;
    assign len_take = is_cr ? len_mid : len_inc(len_mid);

    // a newline or the end of text closes the line
    always_comb begin
        if (emit) begin
            n_bsr = '0;
            n_occ = '0;
            n_len = '0;
            n_ret = 1'b0;
        end else begin
            n_bsr = hit ? '0 : bsr_inc;
            n_occ = occ_take;
            n_len = len_take;
            n_ret = is_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsr <= '0;
            r_occ <= '0;
            r_len <= '0;
            r_ret <= 1'b0;
        end else if (advance) begin
            r_bsr <= n_bsr;
            r_occ <= n_occ;
            r_len <= n_len;
            r_ret <= n_ret;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_occ <= is_nl ? r_occ : occ_take;
            r_out_len <= is_nl ? len_out(r_len) : len_out(len_take);
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.line_matched     = (r_out_occ != '0);
    assign o_out.occurrence_count = r_out_occ;
    assign o_out.line_length      = r_out_len;

    // restart counter never passes the window size
    a_bsr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bsr <= BSR_W'(MAX_PATTERN))
        else $error("restart counter beyond window size");

    // a hit restarts matching past its end
    a_hit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && hit) |=> (r_bsr == '0))
        else $error("restart counter not cleared after a hit");

    // a closing byte leaves a clean line state behind
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_occ == '0 && r_len == '0 && !r_ret && o_out.valid))
        else $error("line state not cleared after a line result");

    // a held byte waits only on a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> (emit && r_out_valid && !o_out.ready))
        else $error("input stage stalled without a blocked result");

endmodule

// ===== sim/line_fixed_string_matcher_top_tb.sv =====
// testbench for the line fixed string matcher: scripted and random text checked per line
`timescale 1ns / 1ps

module line_fixed_string_matcher_top_tb;
    import lfsm_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int RESULT_LATENCY  = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BYTES     = 180;
    localparam int LONG_LINE_BYTES = 150;
    localparam int MAX_REPORTED    = 10;
    localparam int WINDOW_DEPTH    = 32;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_MASK,
        SINK_SLOW
    } t_sink_mode;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    typedef struct packed {
        logic                 matched;
        logic [COUNT_W-1:0]   count;
        logic [LEN_OUT_W-1:0] len;
    } t_line_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfsm_in_if  in_if ();
    lfsm_out_if out_if ();

    line_fixed_string_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the registers
    logic [5:0]   cfg_plen    = 6'd1;
    logic         cfg_fold    = 1'b0;
    logic [255:0] cfg_pattern = '0;

    // predictor copy of the line state
    logic [7:0]           recent_bytes [WINDOW_DEPTH];
    int                   since_restart = 0;
    logic [COUNT_W-1:0]   hit_count     = '0;
    logic [LEN_OUT_W-1:0] line_len      = '0;
    logic                 cr_pending    = 1'b0;

    t_text_beat   text_q [$];
    t_line_report pending_reports [$];

    int bytes_queued     = 0;
    int bytes_accepted   = 0;
    int lines_predicted  = 0;
    int lines_checked    = 0;
    int mismatches       = 0;
    int settings_applied = 0;
    int cycle_count      = 0;

    // pacing of both channels, set per phase
    int           source_gap_max = 0;
    int           gap_left       = 0;
    int           burst_left     = 0;
    t_sink_mode   sink_mode      = SINK_ALWAYS;
    logic [15:0]  stall_mask     = 16'hFFFF;

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("line_fixed_string_matcher_top regression: fail");
            $finish;
        end
    end

    // pattern length as the block uses it
    function automatic int clamp_len(input logic [5:0] pl);
        if (pl == '0) return 1;
        if (pl > 6'(WINDOW_DEPTH)) return WINDOW_DEPTH;
        return int'(pl);
    endfunction

    // letters go to lower case when case is ignored
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | FOLD_BIT;
        if (cfg_fold && lc >= LOWER_A && lc <= LOWER_Z) return lc;
        return c;
    endfunction

    // emit the line summary and start a fresh line
    task automatic close_line();
        t_line_report rep;
        rep.matched = (hit_count != '0);
        rep.count   = hit_count;
        rep.len     = line_len;
        pending_reports.push_back(rep);
        lines_predicted <= lines_predicted + 1;
        since_restart = 0;
        hit_count     = '0;
        line_len      = '0;
        cr_pending    = 1'b0;
    endtask

    // advance the line state by one transferred byte
    task automatic scan_text_byte(input logic [7:0] ch, input logic last);
        int n;
        bit hit;
        if (ch == BYTE_NEWLINE) begin
            close_line();
            return;
        end
        n = clamp_len(cfg_plen);
        // a return only counts once something other than the line end follows it
        if (cr_pending && line_len != '1) line_len = line_len + 1'b1;
        if (ch == BYTE_RETURN) begin
            cr_pending = 1'b1;
        end else begin
            cr_pending = 1'b0;
            if (line_len != '1) line_len = line_len + 1'b1;
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = ch;
        if (since_restart < WINDOW_DEPTH) since_restart++;
        // compare only once a whole pattern fits since the line start or last hit
        if (since_restart >= n) begin
            hit = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (fold_char(recent_bytes[n-1-k]) != fold_char(cfg_pattern[8*k +: 8]))
                    hit = 1'b0;
            end
            if (hit) begin
                if (hit_count != '1) hit_count = hit_count + 1'b1;
                since_restart = 0;
            end
        end
        if (last) close_line();
    endtask

    // text byte source: bursts with random gaps
    always @(posedge i_clk) begin
        t_text_beat beat;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (text_q.size() != 0) begin
                beat = text_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.text_byte   <= beat.ch;
                in_if.end_of_text <= beat.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= (source_gap_max == 0) ? 0 : $urandom_range(0, source_gap_max);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // predict on every byte transfer
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            scan_text_byte(in_if.text_byte, in_if.end_of_text);
            bytes_accepted <= bytes_accepted + 1;
        end
    end

    // result sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS: out_if.ready <= 1'b1;
                SINK_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                SINK_MASK:   out_if.ready <= stall_mask[cycle_count % 16];
                default:     out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic log_mismatch(input bit have_want, input t_line_report want,
                                input t_line_report seen);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            if (have_want)
                $display({"mismatch at line %0d: expected matched=%0b count=%0d len=%0d,",
                          " got matched=%0b count=%0d len=%0d"},
                         lines_checked, want.matched, want.count, want.len,
                         seen.matched, seen.count, seen.len);
            else
                $display({"mismatch at line %0d: unexpected report",
                          " matched=%0b count=%0d len=%0d"},
                         lines_checked, seen.matched, seen.count, seen.len);
        end
    endtask

    // compare each line report transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_line_report seen;
        t_line_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.matched = out_if.line_matched;
            seen.count   = out_if.occurrence_count;
            seen.len     = out_if.line_length;
            if (pending_reports.size() == 0) begin
                log_mismatch(1'b0, seen, seen);
            end else begin
                want = pending_reports.pop_front();
                if (seen.matched !== want.matched || seen.count !== want.count ||
                    seen.len !== want.len)
                    log_mismatch(1'b1, want, seen);
            end
            lines_checked <= lines_checked + 1;
        end
    end

    task automatic push_byte(input logic [7:0] ch, input logic last);
        t_text_beat beat;
        beat.ch   = ch;
        beat.last = last;
        text_q.push_back(beat);
        bytes_queued++;
    endtask

    task automatic push_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], last_on_end && (i == s.len() - 1));
    endtask

    function automatic logic [255:0] text_pattern(input string s);
        logic [255:0] p;
        p = '0;
        for (int i = 0; i < s.len(); i++) p[8*i +: 8] = s[i];
        return p;
    endfunction

    // wait until all bytes are taken and every predicted line has come back
    task automatic settle();
        while (bytes_accepted != bytes_queued || lines_checked < lines_predicted)
            @(posedge i_clk);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    // write all six registers back to back, then mirror them in the predictor
    task automatic program_matcher(input logic [5:0] plen, input logic ic,
                                   input logic [255:0] pat);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PATTERN_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(plen);
        @(posedge i_clk);
        i_cfg_index <= REG_IGNORE_CASE;
        i_cfg_data  <= CFG_DATA_W'(ic);
        for (int w = 0; w < 4; w++) begin
            @(posedge i_clk);
            i_cfg_index <= CFG_IDX_W'(REG_PATTERN_WORD_0 + w);
            i_cfg_data  <= pat[64*w +: 64];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_plen    = plen;
        cfg_fold    = ic;
        cfg_pattern = pat;
        settings_applied++;
    endtask

    // flip letter case now and then, more often when case is folded
    function automatic logic [7:0] vary_case(input logic [7:0] c, input logic freely);
        logic [7:0] lc;
        lc = c | FOLD_BIT;
        if (lc >= LOWER_A && lc <= LOWER_Z && $urandom_range(0, freely ? 1 : 7) == 0)
            return c ^ FOLD_BIT;
        return c;
    endfunction

    // line content: mostly pattern bytes, some letters, a little of anything
    function automatic logic [7:0] filler_byte(input logic [255:0] pat, input int n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return pat[8*$urandom_range(0, n - 1) +: 8];
        if (r < 8) return LOWER_A + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        string        pattern_letters;
        logic [255:0] pat;
        logic [5:0]   plen;
        logic         ic;
        int           n;
        int           nseg;
        int           roll;
        int           phase;
        int           phase_start;
        pattern_letters = "abAB-\015";
        for (int k = 0; k < WINDOW_DEPTH; k++) recent_bytes[k] = '0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = REG_PATTERN_LENGTH;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.text_byte   = '0;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: one zero byte as pattern, byte extremes, empty line
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(BYTE_NEWLINE, 1'b0);
        push_byte(BYTE_NEWLINE, 1'b0);
        settle();

        // zero length acts as one, folded case, returns at end of text and before newline
        program_matcher(6'd0, 1'b1, text_pattern("Q"));
        @(negedge i_clk);
        push_text("qQ\015", 1'b1);
        push_text("\015\015\n", 1'b0);
        settle();

        // newline inside the pattern never matches
        program_matcher(6'd3, 1'b0, text_pattern("a\nb"));
        @(negedge i_clk);
        push_text("a\nb\n", 1'b0);
        settle();

        // return as part of the pattern, then a register change in mid line
        program_matcher(6'd2, 1'b0, text_pattern("x\015"));
        @(negedge i_clk);
        push_text("x\015x\015\n", 1'b0);
        push_text("ab", 1'b0);
        settle();
        program_matcher(6'd1, 1'b0, text_pattern("b"));
        @(negedge i_clk);
        push_text("b\n", 1'b1);
        settle();

        // random phases: well formed lines seeded with the pattern, some noise
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       plen = 6'd63;
                1:       plen = 6'd0;
                2:       plen = 6'd32;
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll < 6)      plen = 6'($urandom_range(1, 6));
                    else if (roll < 9) plen = 6'($urandom_range(7, 32));
                    else               plen = 6'($urandom_range(33, 63));
                end
            endcase
            ic = (phase == 2) ? 1'b1 : 1'($urandom_range(0, 1));
            n  = clamp_len(plen);
            for (int k = 0; k < 8; k++) pat[32*k +: 32] = $urandom;
            if (phase == 2) begin
                pat = '1;
            end else if ($urandom_range(0, 3) != 0) begin
                for (int k = 0; k < n; k++)
                    pat[8*k +: 8] = pattern_letters[$urandom_range(0, pattern_letters.len() - 1)];
            end
            program_matcher(plen, ic, pat);

            @(negedge i_clk);
            if (phase == 0) begin
                source_gap_max = 0;
                sink_mode      = SINK_ALWAYS;
            end else begin
                roll           = $urandom_range(0, 3);
                source_gap_max = (roll == 0) ? 0 : (roll == 1) ? 1 : (roll == 2) ? 3 : 6;
                sink_mode      = t_sink_mode'($urandom_range(0, 3));
            end
            stall_mask  = 16'($urandom_range(1, 65535));
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0) begin
                    // raw noise, end of text now and then
                    nseg = $urandom_range(1, 8);
                    for (int k = 0; k < nseg; k++)
                        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                end else begin
                    nseg = $urandom_range(0, 5);
                    for (int s = 0; s < nseg; s++) begin
                        if ($urandom_range(0, 9) < 4) begin
                            for (int k = 0; k < n; k++)
                                push_byte(vary_case(pat[8*k +: 8], ic), 1'b0);
                        end else begin
                            repeat ($urandom_range(1, 4))
                                push_byte(vary_case(filler_byte(pat, n), ic), 1'b0);
                        end
                    end
                    // line end: newline, return plus newline, end of text
                    roll = $urandom_range(0, 9);
                    if (roll < 7) begin
                        push_byte(BYTE_NEWLINE, 1'b0);
                    end else if (roll == 7) begin
                        push_byte(BYTE_RETURN, 1'b0);
                        push_byte(BYTE_NEWLINE, 1'b0);
                    end else if (roll == 8) begin
                        push_byte(filler_byte(pat, n), 1'b1);
                    end else begin
                        push_byte(BYTE_NEWLINE, 1'b1);
                    end
                end
            end
            settle();
        end

        // one long line of back to back hits ending in a return and newline
        program_matcher(6'd1, 1'b0, text_pattern("a"));
        @(negedge i_clk);
        source_gap_max = 0;
        sink_mode      = SINK_COIN;
        for (int k = 0; k < LONG_LINE_BYTES; k++) push_byte(LOWER_A, 1'b0);
        push_byte(BYTE_RETURN, 1'b0);
        push_byte(BYTE_NEWLINE, 1'b0);
        settle();

        $display("covered %0d text bytes and %0d line reports under %0d register settings,",
                 bytes_accepted, lines_checked, settings_applied);
        $display("with folded case, clamped lengths, returns, end of text and long hit runs");
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("line_fixed_string_matcher_top regression: pass");
        end else begin
            $display("line_fixed_string_matcher_top regression: fail");
        end
        $finish;
    end

endmodule
